// ===== src/alrg_pkg.sv =====
// shared types, constants and helpers for the linear ramp generator
`default_nettype none

package alrg_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int POS_WIDTH      = 14;
    localparam int AMOUNT_WIDTH   = 24;
    localparam int QUOT_WIDTH     = 20;
    localparam int CNT_WIDTH      = 5;

    localparam int POS_MAX     = 9999;
    localparam int AMOUNT_MAX  = 9999999;
    localparam int SPEED_SCALE = 100;
    localparam int POS_RESET   = 5000;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_STOP = 2'd2;
    localparam logic [1:0] OP_POLL = 2'd3;

    localparam logic [1:0] MODE_IMMEDIATE = 2'd0;
    localparam logic [1:0] MODE_SPEED     = 2'd1;
    localparam logic [1:0] MODE_INTERVAL  = 2'd2;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [POS_WIDTH-1:0]    target;
        logic [1:0]              mode;
        logic [AMOUNT_WIDTH-1:0] amount;
    } in_item_t;

    typedef struct packed {
        logic [POS_WIDTH-1:0] position;
        logic                 changed;
    } out_item_t;

    // commands from the sequencer to the shared arithmetic unit
    typedef struct packed {
        logic start_ramp;
        logic start_speed;
    } arith_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_stat_t;

    function automatic logic [POS_WIDTH-1:0] clamp_pos(input logic [POS_WIDTH:0] v);
        if (v > (POS_WIDTH+1)'(POS_MAX))
            clamp_pos = POS_WIDTH'(POS_MAX);
        else
            clamp_pos = v[POS_WIDTH-1:0];
    endfunction

    function automatic logic [AMOUNT_WIDTH-1:0] clamp_amount(
        input logic [AMOUNT_WIDTH-1:0] v
    );
        if (v > AMOUNT_WIDTH'(AMOUNT_MAX))
            clamp_amount = AMOUNT_WIDTH'(AMOUNT_MAX);
        else
            clamp_amount = v;
    endfunction

endpackage

`default_nettype wire

// ===== src/alrg_arith.sv =====
// shared add/subtract unit with shift-add multiply and restoring divide sequencing
`default_nettype none

module alrg_arith #(
    parameter int TIME_WIDTH = alrg_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire alrg_pkg::arith_cmd_t               cmd,
    input  wire logic [TIME_WIDTH-1:0]              ramp_elapsed,
    input  wire logic [TIME_WIDTH-1:0]              ramp_span,
    input  wire logic [alrg_pkg::POS_WIDTH-1:0]     ramp_dist,
    input  wire logic [alrg_pkg::QUOT_WIDTH-1:0]    speed_num,
    input  wire logic [alrg_pkg::AMOUNT_WIDTH-1:0]  speed_rate,
    output alrg_pkg::arith_stat_t                   stat,
    output logic [alrg_pkg::QUOT_WIDTH-1:0]         quot
);

    localparam int PW = alrg_pkg::POS_WIDTH;
    localparam int QW = alrg_pkg::QUOT_WIDTH;
    localparam int AW = alrg_pkg::AMOUNT_WIDTH;
    localparam int CW = alrg_pkg::CNT_WIDTH;
    localparam int DW = (TIME_WIDTH > AW) ? TIME_WIDTH : AW;
    localparam int UW = (TIME_WIDTH + PW > DW + 1) ? TIME_WIDTH + PW : DW + 1;

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_LOAD,
        A_DIV
    } arith_state_t;

    arith_state_t            state_reg;
    logic [UW-1:0]           wrk_reg;
    logic [QW-1:0]           num_reg;
    logic [DW-1:0]           dsr_reg;
    logic [TIME_WIDTH-1:0]   mcand_reg;
    logic [PW-1:0]           mplier_reg;
    logic [QW-1:0]           q_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    done_reg;

    logic [UW-1:0] au_a;
    logic [UW-1:0] au_b;
    logic          au_sub;
    logic [UW:0]   au_res;
    logic          cnt_last;

    // the one adder: accumulate in multiply steps, trial subtract in divide steps
    assign au_sub   = (state_reg == A_DIV);
    assign au_a     = {wrk_reg[UW-2:0], au_sub & num_reg[QW-1]};
    assign au_b     = au_sub ? UW'(dsr_reg) : UW'(mcand_reg);
    assign au_res   = {1'b0, au_a} + {1'b0, (au_sub ? ~au_b : au_b)} + (UW+1)'(au_sub);
    assign cnt_last = (cnt_reg == CW'(1));

    assign stat.busy = (state_reg != A_IDLE);
    assign stat.done = done_reg;
    assign quot      = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= A_IDLE;
            wrk_reg    <= '0;
            num_reg    <= '0;
            dsr_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            q_reg      <= '0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == A_DIV) && cnt_last;
            unique case (state_reg)
                A_IDLE:
                begin
                    if (cmd.start_ramp)
                    begin
                        // elapsed * dist first, then divide by span
                        mcand_reg  <= ramp_elapsed;
                        mplier_reg <= ramp_dist;
                        dsr_reg    <= DW'(ramp_span);
                        wrk_reg    <= '0;
                        cnt_reg    <= CW'(PW);
                        state_reg  <= A_MUL;
                    end
                    else if (cmd.start_speed)
                    begin
                        num_reg   <= speed_num;
                        dsr_reg   <= DW'(speed_rate);
                        wrk_reg   <= '0;
                        q_reg     <= '0;
                        cnt_reg   <= CW'(QW);
                        state_reg <= A_DIV;
                    end
                end
                A_MUL:
                begin
                    wrk_reg    <= mplier_reg[PW-1] ? au_res[UW-1:0] : au_a;
                    mplier_reg <= {mplier_reg[PW-2:0], 1'b0};
                    cnt_reg    <= cnt_reg - CW'(1);
                    if (cnt_last)
                        state_reg <= A_LOAD;
                end
                A_LOAD:
                begin
                    // quotient fits the position width, so the upper part is already below span
                    wrk_reg   <= UW'(wrk_reg >> PW);
                    num_reg   <= {wrk_reg[PW-1:0], {(QW-PW){1'b0}}};
                    q_reg     <= '0;
                    cnt_reg   <= CW'(PW);
                    state_reg <= A_DIV;
                end
                A_DIV:
                begin
                    if (au_res[UW])
                    begin
                        wrk_reg <= au_res[UW-1:0];
                        q_reg   <= {q_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        wrk_reg <= au_a;
                        q_reg   <= {q_reg[QW-2:0], 1'b0};
                    end
                    num_reg <= {num_reg[QW-2:0], 1'b0};
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_last)
                        state_reg <= A_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/axis_linear_ramp_generator_core.sv =====
// top level of the linear ramp generator: sequencer, axis state and output register
`default_nettype none

// channel | signals                       | direction | transfer when
// --------+-------------------------------+-----------+---------------------------
// in      | in_valid, in_stall, in_data   | to block  | in_valid && !in_stall
// out     | out_valid, out_stall, out_data| from block| out_valid && !out_stall
// cfg     | cfg_valid, cfg_ready, cfg_data| to block  | cfg_valid && cfg_ready
//
// one item at a time; in_stall is high from acceptance until the result is registered
// a position evaluation inside a ramp runs in the shared unit as 14 multiply
// steps, a load and 14 divide steps; outside a ramp the shared unit is not used
// a speed set runs two evaluations plus a 20-step divide; a waiting result
// on out stalls only the next completion
// reset clears the clock and loads the axis with position 5000; no clearing pass

module axis_linear_ramp_generator_core #(
    parameter int TIME_WIDTH = alrg_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire alrg_pkg::in_item_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output alrg_pkg::out_item_t                 out_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [alrg_pkg::POS_WIDTH-1:0] cfg_data
);

    localparam int PW = alrg_pkg::POS_WIDTH;
    localparam int QW = alrg_pkg::QUOT_WIDTH;
    localparam int AW = alrg_pkg::AMOUNT_WIDTH;
    localparam int SW = (TIME_WIDTH > AW) ? TIME_WIDTH : AW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_WAIT,
        S_APPLY,
        S_SPD,
        S_FINISH
    } seq_state_t;

    seq_state_t              state_reg;
    logic                    final_reg;
    logic [1:0]              op_reg;
    logic [1:0]              mode_reg;
    logic [PW-1:0]           x_reg;
    logic [AW-1:0]           y_reg;
    logic [TIME_WIDTH-1:0]   now_reg;
    logic [TIME_WIDTH-1:0]   start_time_reg;
    logic [TIME_WIDTH-1:0]   stop_time_reg;
    logic [PW-1:0]           start_pos_reg;
    logic [PW-1:0]           stop_pos_reg;
    logic [PW-1:0]           last_pos_reg;
    logic [PW-1:0]           cur_reg;
    logic                    chg_reg;
    logic                    down_reg;
    logic                    out_valid_reg;
    alrg_pkg::out_item_t     out_data_reg;

    alrg_pkg::arith_cmd_t    acmd;
    alrg_pkg::arith_stat_t   astat;
    logic [QW-1:0]           quot;

    logic                    in_xfer;
    logic                    cfg_xfer;
    logic                    out_load;
    logic [PW-1:0]           in_x;
    logic [AW-1:0]           in_y;
    logic [PW-1:0]           cfg_pos;
    logic                    now_gt_stop;
    logic                    now_gt_start;
    logic                    ramp_down;
    logic [TIME_WIDTH-1:0]   ramp_elapsed;
    logic [TIME_WIDTH-1:0]   ramp_span;
    logic [PW-1:0]           ramp_dist;
    logic [PW-1:0]           speed_dist;
    logic [QW-1:0]           speed_num;
    logic [PW-1:0]           q_pos;
    logic [PW-1:0]           pos_up;
    logic [PW-1:0]           pos_down;
    logic [SW-1:0]           sum_interval;
    logic [SW-1:0]           sum_speed;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !in_valid;
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_load  = (state_reg == S_FINISH) && final_reg && (!out_valid_reg || !out_stall);

    assign in_x    = alrg_pkg::clamp_pos({1'b0, in_data.target});
    assign in_y    = alrg_pkg::clamp_amount(in_data.amount);
    assign cfg_pos = alrg_pkg::clamp_pos({1'b0, cfg_data});

    assign now_gt_stop  = (now_reg > stop_time_reg);
    assign now_gt_start = (now_reg > start_time_reg);
    assign ramp_down    = (stop_pos_reg < start_pos_reg);
    assign ramp_elapsed = now_reg - start_time_reg;
    assign ramp_span    = stop_time_reg - start_time_reg;
    assign ramp_dist    = ramp_down ? (start_pos_reg - stop_pos_reg)
                                    : (stop_pos_reg - start_pos_reg);

    assign speed_dist = (x_reg >= cur_reg) ? (x_reg - cur_reg) : (cur_reg - x_reg);
    assign speed_num  = QW'(speed_dist) * QW'(alrg_pkg::SPEED_SCALE);

    // quotient never exceeds the ramp distance
    assign q_pos    = quot[PW-1:0];
    assign pos_up   = alrg_pkg::clamp_pos((PW+1)'(start_pos_reg) + (PW+1)'(q_pos));
    assign pos_down = (q_pos >= start_pos_reg) ? '0 : (start_pos_reg - q_pos);

    // time sums wrap at the clock width
    assign sum_interval = SW'(now_reg) + SW'(y_reg);
    assign sum_speed    = SW'(now_reg) + SW'(quot);

    always_comb
    begin
        acmd.start_ramp  = (state_reg == S_EVAL) && !now_gt_stop && now_gt_start;
        acmd.start_speed = (state_reg == S_APPLY) && (op_reg == alrg_pkg::OP_SET)
                           && (mode_reg == alrg_pkg::MODE_SPEED) && (y_reg != '0);
    end

    alrg_arith #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_arith (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (acmd),
        .ramp_elapsed (ramp_elapsed),
        .ramp_span    (ramp_span),
        .ramp_dist    (ramp_dist),
        .speed_num    (speed_num),
        .speed_rate   (y_reg),
        .stat         (astat),
        .quot         (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            final_reg      <= 1'b0;
            op_reg         <= alrg_pkg::OP_TICK;
            mode_reg       <= alrg_pkg::MODE_IMMEDIATE;
            x_reg          <= '0;
            y_reg          <= '0;
            now_reg        <= '0;
            start_time_reg <= '0;
            stop_time_reg  <= TIME_WIDTH'(alrg_pkg::POS_RESET);
            start_pos_reg  <= PW'(alrg_pkg::POS_RESET);
            stop_pos_reg   <= PW'(alrg_pkg::POS_RESET);
            last_pos_reg   <= PW'(alrg_pkg::POS_RESET);
            cur_reg        <= '0;
            chg_reg        <= 1'b0;
            down_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_xfer)
                    begin
                        start_time_reg <= '0;
                        stop_time_reg  <= TIME_WIDTH'(cfg_pos);
                        start_pos_reg  <= cfg_pos;
                        stop_pos_reg   <= cfg_pos;
                        last_pos_reg   <= cfg_pos;
                    end
                    else if (in_xfer)
                    begin
                        op_reg    <= in_data.opcode;
                        mode_reg  <= in_data.mode;
                        x_reg     <= in_x;
                        y_reg     <= in_y;
                        chg_reg   <= 1'b0;
                        state_reg <= S_EVAL;
                        if (in_data.opcode == alrg_pkg::OP_TICK)
                        begin
                            now_reg   <= now_reg + TIME_WIDTH'(1);
                            final_reg <= 1'b1;
                        end
                        else if (in_data.opcode == alrg_pkg::OP_SET
                                 && in_data.mode != alrg_pkg::MODE_SPEED
                                 && in_data.mode != alrg_pkg::MODE_INTERVAL)
                        begin
                            // immediate: a nonzero amount keeps start point and stop time
                            start_time_reg <= now_reg;
                            stop_pos_reg   <= in_x;
                            if (in_y == '0)
                            begin
                                stop_time_reg <= now_reg;
                                start_pos_reg <= in_x;
                            end
                            final_reg <= 1'b1;
                        end
                        else
                        begin
                            final_reg <= 1'b0;
                        end
                    end
                end
                S_EVAL:
                begin
                    if (now_gt_stop)
                    begin
                        cur_reg   <= stop_pos_reg;
                        state_reg <= S_FINISH;
                    end
                    else if (now_gt_start)
                    begin
                        down_reg  <= ramp_down;
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        cur_reg   <= start_pos_reg;
                        state_reg <= S_FINISH;
                    end
                end
                S_WAIT:
                begin
                    if (astat.done)
                    begin
                        cur_reg   <= down_reg ? pos_down : pos_up;
                        state_reg <= S_FINISH;
                    end
                end
                S_APPLY:
                begin
                    final_reg <= 1'b1;
                    state_reg <= acmd.start_speed ? S_SPD : S_EVAL;
                    unique case (op_reg)
                        alrg_pkg::OP_SET:
                        begin
                            priority case (mode_reg)
                                alrg_pkg::MODE_SPEED:
                                begin
                                    if (y_reg == '0)
                                    begin
                                        // zero speed arrives at once
                                        start_pos_reg  <= cur_reg;
                                        stop_time_reg  <= now_reg;
                                        start_time_reg <= now_reg;
                                        stop_pos_reg   <= x_reg;
                                    end
                                end
                                alrg_pkg::MODE_INTERVAL:
                                begin
                                    start_pos_reg  <= cur_reg;
                                    stop_time_reg  <= sum_interval[TIME_WIDTH-1:0];
                                    start_time_reg <= now_reg;
                                    stop_pos_reg   <= x_reg;
                                end
                                default:
                                begin
                                    start_time_reg <= now_reg;
                                end
                            endcase
                        end
                        alrg_pkg::OP_STOP:
                        begin
                            start_pos_reg  <= cur_reg;
                            stop_pos_reg   <= cur_reg;
                            start_time_reg <= now_reg;
                            stop_time_reg  <= now_reg;
                        end
                        alrg_pkg::OP_POLL:
                        begin
                            if (cur_reg != last_pos_reg)
                            begin
                                last_pos_reg <= cur_reg;
                                chg_reg      <= 1'b1;
                            end
                        end
                        alrg_pkg::OP_TICK:
                        begin
                            // ticks never come through here
                        end
                    endcase
                end
                S_SPD:
                begin
                    if (astat.done)
                    begin
                        start_pos_reg  <= cur_reg;
                        stop_time_reg  <= sum_speed[TIME_WIDTH-1:0];
                        start_time_reg <= now_reg;
                        stop_pos_reg   <= x_reg;
                        final_reg      <= 1'b1;
                        state_reg      <= S_EVAL;
                    end
                end
                S_FINISH:
                begin
                    if (!final_reg)
                    begin
                        state_reg <= S_APPLY;
                    end
                    else if (out_load)
                    begin
                        out_data_reg.position <= cur_reg;
                        out_data_reg.changed  <= chg_reg;
                        state_reg             <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // an accepted item always leaves the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg != S_IDLE)
        else $error("accepted item did not start the sequencer");

    // the shared unit finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        astat.done |-> (state_reg == S_WAIT || state_reg == S_SPD))
        else $error("arithmetic result arrived with no one waiting");

    // a new operation is never issued to a busy unit
    assert property (@(posedge clk) disable iff (!rst_n)
        (acmd.start_ramp || acmd.start_speed) |-> !astat.busy)
        else $error("arithmetic unit started while busy");

    // reported positions stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.position <= PW'(alrg_pkg::POS_MAX))
        else $error("position out of range");

endmodule

`default_nettype wire

// ===== sim/tb_axis_linear_ramp_generator_core.sv =====
// self-checking testbench for the linear ramp generator core
module tb_axis_linear_ramp_generator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TW = alrg_pkg::TIME_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 235;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        alrg_pkg::in_item_t  item;
        logic                typed;
        alrg_pkg::out_item_t want;
    } dir_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    alrg_pkg::in_item_t             in_data = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    alrg_pkg::out_item_t            out_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [alrg_pkg::POS_WIDTH-1:0] cfg_data = '0;

    // axis state as the block should hold it
    logic [TW-1:0]                  clock_ms;
    logic [TW-1:0]                  ramp_t0;
    logic [TW-1:0]                  ramp_t1;
    logic [alrg_pkg::POS_WIDTH-1:0] home_pos;
    logic [alrg_pkg::POS_WIDTH-1:0] ramp_p0;
    logic [alrg_pkg::POS_WIDTH-1:0] ramp_p1;
    logic [alrg_pkg::POS_WIDTH-1:0] polled_pos;

    alrg_pkg::out_item_t due_results[$];
    dir_row_t            dir_rows[$];
    alrg_pkg::out_item_t got_want;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int cycles = 0;
    int items_sent = 0;
    int sets_sent = 0;
    int polls_sent = 0;
    int results_seen = 0;
    int home_writes = 0;

    axis_linear_ramp_generator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     due_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    function automatic void load_home(input logic [alrg_pkg::POS_WIDTH-1:0] value);
        home_pos   = (value > alrg_pkg::POS_MAX) ? alrg_pkg::POS_WIDTH'(alrg_pkg::POS_MAX)
                                                 : value;
        ramp_t0    = '0;
        ramp_t1    = TW'(home_pos);
        ramp_p0    = home_pos;
        ramp_p1    = home_pos;
        polled_pos = home_pos;
    endfunction

    // linear interpolation between the ramp end points, truncating toward zero
    function automatic logic [alrg_pkg::POS_WIDTH-1:0] ramp_position();
        logic [TW-1:0] elapsed;
        logic [TW-1:0] span;
        logic [63:0]   mag;
        if (clock_ms > ramp_t1)
            return ramp_p1;
        if (clock_ms > ramp_t0)
        begin
            elapsed = clock_ms - ramp_t0;
            span    = ramp_t1 - ramp_t0;
            if (ramp_p1 >= ramp_p0)
            begin
                mag = (64'(elapsed) * 64'(ramp_p1 - ramp_p0)) / 64'(span);
                return (64'(ramp_p0) + mag > alrg_pkg::POS_MAX)
                       ? alrg_pkg::POS_WIDTH'(alrg_pkg::POS_MAX)
                       : alrg_pkg::POS_WIDTH'(64'(ramp_p0) + mag);
            end
            mag = (64'(elapsed) * 64'(ramp_p0 - ramp_p1)) / 64'(span);
            return (mag >= 64'(ramp_p0)) ? '0 : alrg_pkg::POS_WIDTH'(64'(ramp_p0) - mag);
        end
        return ramp_p0;
    endfunction

    function automatic alrg_pkg::out_item_t ramp_step(input alrg_pkg::in_item_t it);
        logic [alrg_pkg::POS_WIDTH-1:0]    cur;
        logic [alrg_pkg::POS_WIDTH-1:0]    tgt;
        logic [alrg_pkg::AMOUNT_WIDTH-1:0] amt;
        logic [TW-1:0]                     gap;
        logic [TW-1:0]                     travel;
        alrg_pkg::out_item_t               res;
        res = '0;
        case (it.opcode)
            alrg_pkg::OP_TICK:
                clock_ms = clock_ms + 1'b1;
            alrg_pkg::OP_SET:
            begin
                tgt = (it.target > alrg_pkg::POS_MAX)
                      ? alrg_pkg::POS_WIDTH'(alrg_pkg::POS_MAX) : it.target;
                amt = (it.amount > alrg_pkg::AMOUNT_MAX)
                      ? alrg_pkg::AMOUNT_WIDTH'(alrg_pkg::AMOUNT_MAX) : it.amount;
                if (it.mode == alrg_pkg::MODE_SPEED)
                begin
                    cur    = ramp_position();
                    gap    = (tgt >= cur) ? TW'(tgt - cur) : TW'(cur - tgt);
                    travel = (amt == 0) ? '0 : (gap * alrg_pkg::SPEED_SCALE) / TW'(amt);
                    ramp_p0 = cur;
                    ramp_t1 = clock_ms + travel;
                end
                else if (it.mode == alrg_pkg::MODE_INTERVAL)
                begin
                    ramp_p0 = ramp_position();
                    ramp_t1 = clock_ms + TW'(amt);
                end
                else if (amt == 0)
                begin
                    ramp_t1 = clock_ms;
                    ramp_p0 = tgt;
                end
                // immediate mode with nonzero amount keeps the old start point and stop time
                ramp_t0 = clock_ms;
                ramp_p1 = tgt;
            end
            alrg_pkg::OP_STOP:
            begin
                cur     = ramp_position();
                ramp_p0 = cur;
                ramp_p1 = cur;
                ramp_t0 = clock_ms;
                ramp_t1 = clock_ms;
            end
            alrg_pkg::OP_POLL:
            begin
                cur = ramp_position();
                if (cur != polled_pos)
                begin
                    polled_pos  = cur;
                    res.changed = 1'b1;
                end
            end
        endcase
        res.position = ramp_position();
        return res;
    endfunction

    function automatic dir_row_t mk_row(input logic [1:0] op, input int tgt,
                                        input logic [1:0] md, input int amt,
                                        input logic typed, input int pos,
                                        input logic chg);
        dir_row_t r;
        r.item.opcode   = op;
        r.item.target   = alrg_pkg::POS_WIDTH'(tgt);
        r.item.mode     = md;
        r.item.amount   = alrg_pkg::AMOUNT_WIDTH'(amt);
        r.typed         = typed;
        r.want.position = alrg_pkg::POS_WIDTH'(pos);
        r.want.changed  = chg;
        return r;
    endfunction

    function automatic alrg_pkg::in_item_t rand_item();
        alrg_pkg::in_item_t it;
        int unsigned        r;
        // fields that the operation does not use carry noise
        it.target = alrg_pkg::POS_WIDTH'($urandom);
        it.mode   = 2'($urandom);
        it.amount = alrg_pkg::AMOUNT_WIDTH'($urandom);
        r = $urandom_range(99);
        if (r < 50)
            it.opcode = alrg_pkg::OP_TICK;
        else if (r < 74)
        begin
            it.opcode = alrg_pkg::OP_SET;
            it.target = ($urandom_range(9) == 0)
                        ? alrg_pkg::POS_WIDTH'($urandom)
                        : alrg_pkg::POS_WIDTH'($urandom_range(alrg_pkg::POS_MAX));
            r = $urandom_range(15);
            it.mode = (r == 0) ? MODE_UNUSED : (r < 6) ? alrg_pkg::MODE_IMMEDIATE
                    : (r < 11) ? alrg_pkg::MODE_SPEED : alrg_pkg::MODE_INTERVAL;
            if (it.mode == alrg_pkg::MODE_SPEED)
                it.amount = ($urandom_range(9) == 0) ? alrg_pkg::AMOUNT_WIDTH'($urandom)
                          : ($urandom_range(7) == 0) ? '0
                          : alrg_pkg::AMOUNT_WIDTH'($urandom_range(1, 3000));
            else if (it.mode == alrg_pkg::MODE_INTERVAL)
                it.amount = ($urandom_range(9) == 0) ? alrg_pkg::AMOUNT_WIDTH'($urandom)
                          : alrg_pkg::AMOUNT_WIDTH'($urandom_range(40));
            else
                it.amount = ($urandom_range(1) == 0) ? '0
                          : alrg_pkg::AMOUNT_WIDTH'($urandom);
        end
        else if (r < 80)
            it.opcode = alrg_pkg::OP_STOP;
        else
            it.opcode = alrg_pkg::OP_POLL;
        return it;
    endfunction

    task automatic note_error(input string what, input int want, input int got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s mismatch, expected %0d got %0d", $realtime, what, want, got);
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input alrg_pkg::in_item_t it, input logic typed,
                             input alrg_pkg::out_item_t want);
        alrg_pkg::out_item_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        pred = ramp_step(it);
        due_results.push_back(typed ? want : pred);
        items_sent++;
        if (it.opcode == alrg_pkg::OP_SET)
            sets_sent++;
        if (it.opcode == alrg_pkg::OP_POLL)
            polls_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_home(input logic [alrg_pkg::POS_WIDTH-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        load_home(value);
        home_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (due_results.size() == 0)
                note_error("unexpected result, position", -1, out_data.position);
            else
            begin
                got_want = due_results.pop_front();
                if (out_data.position !== got_want.position)
                    note_error("position", got_want.position, out_data.position);
                if (out_data.changed !== got_want.changed)
                    note_error("changed", got_want.changed, out_data.changed);
            end
        end
    end

    initial
    begin
        logic [alrg_pkg::POS_WIDTH-1:0] home_list[PHASES];
        alrg_pkg::out_item_t            none;
        none = '0;
        home_list = '{14'd0, 14'd9999, 14'h3FFF, 14'd1, 14'd9998, 14'd0, 14'd0, 14'd0};
        for (int i = 5; i < PHASES; i++)
            home_list[i] = alrg_pkg::POS_WIDTH'($urandom);
        clock_ms = '0;
        load_home(alrg_pkg::POS_WIDTH'(alrg_pkg::POS_RESET));

        // typed expectations follow from the reset position of 5000
        dir_rows.push_back(mk_row(alrg_pkg::OP_POLL, 0, alrg_pkg::MODE_IMMEDIATE, 0,
                                  1, 5000, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_TICK, 16383, MODE_UNUSED, 24'hFFFFFF,
                                  1, 5000, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_SET, 9999, alrg_pkg::MODE_IMMEDIATE, 0,
                                  1, 9999, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_POLL, 0, alrg_pkg::MODE_IMMEDIATE, 0,
                                  1, 9999, 1));
        dir_rows.push_back(mk_row(alrg_pkg::OP_POLL, 0, alrg_pkg::MODE_IMMEDIATE, 0,
                                  1, 9999, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_SET, 16383, alrg_pkg::MODE_IMMEDIATE, 0,
                                  1, 9999, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_SET, 0, alrg_pkg::MODE_IMMEDIATE, 0,
                                  1, 0, 0));
        // zero speed arrives at once
        dir_rows.push_back(mk_row(alrg_pkg::OP_SET, 9999, alrg_pkg::MODE_SPEED, 0,
                                  0, 0, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_TICK, 0, alrg_pkg::MODE_IMMEDIATE, 0,
                                  1, 9999, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_SET, 0, alrg_pkg::MODE_SPEED, 100000,
                                  0, 0, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_TICK, 0, alrg_pkg::MODE_IMMEDIATE, 0,
                                  0, 0, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_TICK, 0, alrg_pkg::MODE_IMMEDIATE, 0,
                                  0, 0, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_TICK, 0, alrg_pkg::MODE_IMMEDIATE, 0,
                                  0, 0, 0));
        // interval beyond the amount limit
        dir_rows.push_back(mk_row(alrg_pkg::OP_SET, 5000, alrg_pkg::MODE_INTERVAL,
                                  24'hFFFFFF, 0, 0, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_TICK, 0, alrg_pkg::MODE_IMMEDIATE, 0,
                                  0, 0, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_TICK, 0, alrg_pkg::MODE_IMMEDIATE, 0,
                                  0, 0, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_STOP, 0, alrg_pkg::MODE_IMMEDIATE, 0,
                                  0, 0, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_TICK, 0, alrg_pkg::MODE_IMMEDIATE, 0,
                                  0, 0, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_SET, 9999, alrg_pkg::MODE_INTERVAL, 0,
                                  0, 0, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_TICK, 0, alrg_pkg::MODE_IMMEDIATE, 0,
                                  0, 0, 0));
        // immediate with nonzero amount keeps old start point and stop time
        dir_rows.push_back(mk_row(alrg_pkg::OP_SET, 100, alrg_pkg::MODE_IMMEDIATE, 1,
                                  0, 0, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_SET, 1234, MODE_UNUSED, 0, 1, 1234, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_SET, 1234, alrg_pkg::MODE_SPEED,
                                  24'hFFFFFF, 0, 0, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_POLL, 16383, MODE_UNUSED, 24'hFFFFFF,
                                  0, 0, 0));
        dir_rows.push_back(mk_row(alrg_pkg::OP_STOP, 16383, MODE_UNUSED, 24'hFFFFFF,
                                  0, 0, 0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            case (ph % 4)
                1: send_idle_pct = 68;
                2: recv_stall_pct = 68;
                3:
                begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
                default: ;
            endcase
            write_home(home_list[ph]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // now and then let every pending transfer land before going on
                if ($urandom_range(63) == 0)
                    drain();
                send_item(rand_item(), 1'b0, none);
            end
            drain();
        end

        repeat (20) @(negedge clk);
        $display("sent %0d commands (%0d sets, %0d polls), checked %0d results",
                 items_sent, sets_sent, polls_sent, results_seen);
        $display("used %0d home position settings, %0d errors", home_writes + 1, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== axis_linear_ramp_generator_core.f =====
src/alrg_pkg.sv
src/alrg_arith.sv
src/axis_linear_ramp_generator_core.sv
sim/tb_axis_linear_ramp_generator_core.sv
